[sv/dsp_pkg.sv]
// ----------------------------------------------------------------------------
// dsp_pkg
// shared constants and controller/datapath interface types for the
// shortest path unit
// ----------------------------------------------------------------------------
package dsp_pkg;

  localparam int ID_BITS          = 6;
  localparam int WEIGHT_IN_BITS   = 16;
  localparam int DIST_OUT_BITS    = 22;
  localparam int DIST_OUT_MAX     = 4194303;
  localparam int DEF_NUM_VERTICES = 64;
  localparam int DEF_WEIGHT_BITS  = 16;

  localparam logic OP_EDGE  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic clr_step;
    logic edge_wr;
    logic q_load;
    logic init;
    logic scan_step;
    logic settle;
    logic relax_step;
    logic scan_start;
    logic fin;
    logic trace_step;
    logic trace_end;
    logic trace_load;
    logic emit_ld;
    logic nopath_ld;
  } dsp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic q_bad;
    logic cnt_last;
    logic any;
    logic sel_is_end;
    logic end_reached;
    logic trace_stop;
    logic emit_last;
    logic out_free;
  } dsp_sts_t;

endpackage

[sv/dsp_ctrl.sv]
// ----------------------------------------------------------------------------
// dsp_ctrl
// sequencer for clearing, edge loading, search rounds, path trace and emit
// ----------------------------------------------------------------------------
module dsp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_ready,
  input  dsp_pkg::dsp_sts_t sts,
  output dsp_pkg::dsp_cmd_t cmd
);
  import dsp_pkg::*;

  typedef enum logic [12:0] {
    S_CLEAR     = 13'b0000000000001,
    S_IDLE      = 13'b0000000000010,
    S_INIT      = 13'b0000000000100,
    S_SCAN      = 13'b0000000001000,
    S_SCAN_END  = 13'b0000000010000,
    S_DECIDE    = 13'b0000000100000,
    S_RELAX     = 13'b0000001000000,
    S_RELAX_END = 13'b0000010000000,
    S_TRACE_RD  = 13'b0000100000000,
    S_TRACE_WR  = 13'b0001000000000,
    S_EMIT_RD   = 13'b0010000000000,
    S_EMIT_LD   = 13'b0100000000000,
    S_NOPATH    = 13'b1000000000000
  } dsp_state_t;

  dsp_state_t state_r, state_nxt;
  logic       acc;

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          if (in_op == OP_EDGE) begin
            cmd.edge_wr = 1'b1;
          end else begin
            cmd.q_load = 1'b1;
            state_nxt  = sts.q_bad ? S_NOPATH : S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.cnt_last) state_nxt = S_SCAN_END;
      end
      S_SCAN_END: state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (!sts.any || sts.sel_is_end) begin
          cmd.fin   = 1'b1;
          state_nxt = sts.end_reached ? S_TRACE_RD : S_NOPATH;
        end else begin
          cmd.settle = 1'b1;
          state_nxt  = S_RELAX;
        end
      end
      S_RELAX: begin
        cmd.relax_step = 1'b1;
        if (sts.cnt_last) state_nxt = S_RELAX_END;
      end
      S_RELAX_END: begin
        cmd.scan_start = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_TRACE_RD: begin
        if (sts.trace_stop) begin
          cmd.trace_end = 1'b1;
          state_nxt     = S_EMIT_RD;
        end else begin
          cmd.trace_step = 1'b1;
          state_nxt      = S_TRACE_WR;
        end
      end
      S_TRACE_WR: begin
        cmd.trace_load = 1'b1;
        state_nxt      = S_TRACE_RD;
      end
      S_EMIT_RD: state_nxt = S_EMIT_LD;
      S_EMIT_LD: begin
        if (sts.out_free) begin
          cmd.emit_ld = 1'b1;
          state_nxt   = sts.emit_last ? S_IDLE : S_EMIT_RD;
        end
      end
      S_NOPATH: begin
        if (sts.out_free) begin
          cmd.nopath_ld = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/dsp_datapath.sv]
// ----------------------------------------------------------------------------
// dsp_datapath
// adjacency, distance, predecessor and path memories with scan/relax logic
// ----------------------------------------------------------------------------
module dsp_datapath #(
  parameter int NUM_VERTICES = dsp_pkg::DEF_NUM_VERTICES,
  parameter int WEIGHT_BITS  = dsp_pkg::DEF_WEIGHT_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [dsp_pkg::ID_BITS-1:0]         in_from_vertex,
  input  logic [dsp_pkg::ID_BITS-1:0]         in_to_vertex,
  input  logic [dsp_pkg::WEIGHT_IN_BITS-1:0]  in_edge_weight,
  input  dsp_pkg::dsp_cmd_t                   cmd,
  output dsp_pkg::dsp_sts_t                   sts,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                out_found,
  output logic [dsp_pkg::ID_BITS-1:0]         out_path_node,
  output logic [dsp_pkg::DIST_OUT_BITS-1:0]   out_total_distance,
  output logic                                out_last
);
  import dsp_pkg::*;

  localparam int VW = $clog2(NUM_VERTICES);
  localparam int EW = $clog2(NUM_VERTICES * NUM_VERTICES);
  localparam int DW = WEIGHT_BITS + VW;
  localparam int W  = WEIGHT_BITS;

  // memories
  logic [W:0]    emem [NUM_VERTICES*NUM_VERTICES];
  logic [DW-1:0] dmem [NUM_VERTICES];
  logic [VW-1:0] pmem [NUM_VERTICES];
  logic [VW-1:0] pbuf [NUM_VERTICES];

  logic [W:0]    emem_q_r;
  logic [DW-1:0] dmem_q_r;
  logic [VW-1:0] pmem_q_r;
  logic [VW-1:0] pq_r;

  logic [NUM_VERTICES-1:0] known_r, reached_r, settled_r;
  logic [EW-1:0] clr_r;
  logic [VW-1:0] s_r, e_r, cnt_r, sel_r, p_idx_r, cur_r, len_r, k_r;
  logic [DW-1:0] min_r;
  logic          any_r, p_scan_r, p_relax_r;
  logic [DIST_OUT_BITS-1:0] tot_r;

  logic          out_valid_r, out_found_r, out_last_r;
  logic [ID_BITS-1:0]       out_node_r;
  logic [DIST_OUT_BITS-1:0] out_dist_r;

  logic          a_ok, b_ok;
  logic [VW-1:0] a_idx, b_idx;
  logic          emem_we;
  logic [EW-1:0] emem_wa, emem_ra;
  logic [W:0]    emem_wd;
  logic [DW:0]   nd;
  logic          cand, upd, dmem_we, pbuf_we, out_free;
  logic [VW-1:0] dmem_wa, pbuf_wd;
  logic [DW-1:0] dmem_wd;

  assign a_ok  = 32'(in_from_vertex) < NUM_VERTICES;
  assign b_ok  = 32'(in_to_vertex) < NUM_VERTICES;
  assign a_idx = VW'(in_from_vertex);
  assign b_idx = VW'(in_to_vertex);

  // edge store port: clearing pass or edge load
  always_comb begin
    emem_we = cmd.clr_step || (cmd.edge_wr && a_ok && b_ok);
    emem_wa = cmd.clr_step ? clr_r
                           : EW'(EW'(a_idx) * EW'(NUM_VERTICES) + EW'(b_idx));
    emem_wd = cmd.clr_step ? '0 : {1'b1, W'(in_edge_weight)};
    emem_ra = EW'(EW'(sel_r) * EW'(NUM_VERTICES) + EW'(cnt_r));
  end

  always_ff @(posedge clk) begin
    if (emem_we) emem[emem_wa] <= emem_wd;
    emem_q_r <= emem[emem_ra];
  end

  // scan and relax evaluation on registered read data
  assign nd   = {1'b0, min_r} + (DW+1)'(emem_q_r[W-1:0]);
  assign cand = p_scan_r && !settled_r[p_idx_r] && reached_r[p_idx_r] &&
                (!any_r || dmem_q_r < min_r);
  assign upd  = p_relax_r && emem_q_r[W] && !settled_r[p_idx_r] &&
                (!reached_r[p_idx_r] || nd < {1'b0, dmem_q_r});

  always_comb begin
    dmem_we = cmd.init || upd;
    dmem_wa = cmd.init ? s_r : p_idx_r;
    dmem_wd = cmd.init ? '0 : nd[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (dmem_we) dmem[dmem_wa] <= dmem_wd;
    dmem_q_r <= dmem[cnt_r];
  end

  always_ff @(posedge clk) begin
    if (upd) pmem[p_idx_r] <= sel_r;
    pmem_q_r <= pmem[cur_r];
  end

  assign pbuf_we = cmd.trace_step || cmd.trace_end;
  assign pbuf_wd = cmd.trace_end ? s_r : cur_r;

  always_ff @(posedge clk) begin
    if (pbuf_we) pbuf[len_r] <= pbuf_wd;
    pq_r <= pbuf[k_r];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= '0;
      known_r   <= '0;
      any_r     <= 1'b0;
      p_scan_r  <= 1'b0;
      p_relax_r <= 1'b0;
    end else begin
      p_scan_r  <= cmd.scan_step;
      p_relax_r <= cmd.relax_step;
      if (cmd.clr_step) clr_r <= EW'(clr_r + 1'b1);
      if (cmd.edge_wr && a_ok && b_ok) begin
        known_r[a_idx] <= 1'b1;
        known_r[b_idx] <= 1'b1;
      end
      if (cmd.init || cmd.scan_start) any_r <= 1'b0;
      else if (cand) any_r <= 1'b1;
    end
  end

  // search and trace registers
  always_ff @(posedge clk) begin
    p_idx_r <= cnt_r;
    if (cmd.q_load) begin
      s_r <= a_idx;
      e_r <= b_idx;
    end
    if (cmd.init) begin
      settled_r <= ~known_r;
      reached_r <= NUM_VERTICES'(1) << s_r;
    end else begin
      if (cmd.settle) settled_r[sel_r] <= 1'b1;
      if (upd) reached_r[p_idx_r] <= 1'b1;
    end
    if (cmd.init || cmd.scan_start || cmd.settle) cnt_r <= '0;
    else if (cmd.scan_step || cmd.relax_step) cnt_r <= VW'(cnt_r + 1'b1);
    if (cand) begin
      min_r <= dmem_q_r;
      sel_r <= p_idx_r;
    end
    if (cmd.fin) begin
      if (!any_r) tot_r <= '0;
      else if (min_r > DW'(DIST_OUT_MAX)) tot_r <= DIST_OUT_BITS'(DIST_OUT_MAX);
      else tot_r <= DIST_OUT_BITS'(min_r);
      cur_r <= e_r;
      len_r <= '0;
    end
    if (cmd.trace_step) len_r <= VW'(len_r + 1'b1);
    if (cmd.trace_load) cur_r <= pmem_q_r;
    if (cmd.trace_end) k_r <= len_r;
    else if (cmd.emit_ld) k_r <= VW'(k_r - 1'b1);
  end

  // result register
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_ld || cmd.nopath_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      out_found_r <= 1'b1;
      out_node_r  <= ID_BITS'(pq_r);
      out_dist_r  <= tot_r;
      out_last_r  <= (k_r == '0);
    end else if (cmd.nopath_ld) begin
      out_found_r <= 1'b0;
      out_node_r  <= '0;
      out_dist_r  <= '0;
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_path_node      = out_node_r;
  assign out_total_distance = out_dist_r;
  assign out_last           = out_last_r;

  always_comb begin
    sts.clr_last    = (clr_r == EW'(NUM_VERTICES * NUM_VERTICES - 1));
    sts.q_bad       = !a_ok || !b_ok ||
                      (in_to_vertex != in_from_vertex && !known_r[b_idx]);
    sts.cnt_last    = (cnt_r == VW'(NUM_VERTICES - 1));
    sts.any         = any_r;
    sts.sel_is_end  = (sel_r == e_r);
    sts.end_reached = reached_r[e_r];
    sts.trace_stop  = (cur_r == s_r) || (len_r == VW'(NUM_VERTICES - 1));
    sts.emit_last   = (k_r == '0);
    sts.out_free    = out_free;
  end

endmodule

[sv/dijkstra_shortest_path_unit.sv]
// ----------------------------------------------------------------------------
// dijkstra_shortest_path_unit
// adjacency-matrix shortest path engine: edge loads and path queries
// ----------------------------------------------------------------------------
// edge transfer: the next item can follow straight away
// query: per round one distance scan and one relax sweep over the adjacency
//   row, up to N rounds, then a read and a load step per path node for the
//   predecessor trace and a read and a load step per emitted result, the load waiting while the output is held
// reset: synchronous active-low; afterwards a clearing pass over all N*N edge
//   entries (4096 at 64 vertices) empties the edge store before in_ready rises
module dijkstra_shortest_path_unit #(
  parameter int NUM_VERTICES = dsp_pkg::DEF_NUM_VERTICES,
  parameter int WEIGHT_BITS  = dsp_pkg::DEF_WEIGHT_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_op,
  input  logic [dsp_pkg::ID_BITS-1:0]         in_from_vertex,
  input  logic [dsp_pkg::ID_BITS-1:0]         in_to_vertex,
  input  logic [dsp_pkg::WEIGHT_IN_BITS-1:0]  in_edge_weight,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_found,
  output logic [dsp_pkg::ID_BITS-1:0]         out_path_node,
  output logic [dsp_pkg::DIST_OUT_BITS-1:0]   out_total_distance,
  output logic                                out_last
);
  import dsp_pkg::*;

  // command and status between sequencer and datapath
  dsp_cmd_t cmd;
  dsp_sts_t sts;

  // sequencer: clearing pass, idle, search rounds, trace and emit
  dsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // memories, scan/relax evaluation and the result register
  dsp_datapath #(
    .NUM_VERTICES (NUM_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_from_vertex     (in_from_vertex),
    .in_to_vertex       (in_to_vertex),
    .in_edge_weight     (in_edge_weight),
    .cmd                (cmd),
    .sts                (sts),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_found          (out_found),
    .out_path_node      (out_path_node),
    .out_total_distance (out_total_distance),
    .out_last           (out_last)
  );

endmodule

[sv/dsp_checker.sv]
// ----------------------------------------------------------------------------
// dsp_checker
// port-level checks on the shortest path unit, bound to the top level
// ----------------------------------------------------------------------------
module dsp_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                in_op,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                out_found,
  input logic [dsp_pkg::ID_BITS-1:0]         out_path_node,
  input logic [dsp_pkg::DIST_OUT_BITS-1:0]   out_total_distance,
  input logic                                out_last
);
  import dsp_pkg::*;

  // nothing pending straight after reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_path_node) &&
      $stable(out_total_distance) && $stable(out_found) && $stable(out_last))
    else $error("stalled result changed");

  // a no-path answer is a single cleared result
  a_nopath: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_last && out_path_node == '0 &&
      out_total_distance == '0)
    else $error("malformed no-path result");

  // a query transfer takes the block busy
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == OP_QUERY |=> !in_ready)
    else $error("input ready right after a query");

endmodule

bind dijkstra_shortest_path_unit dsp_checker u_dsp_checker (.*);
